// ===== hdl/memory_aware_job_governor_macros.svh =====
// ----------------------------------------------------------------------------
// memory_aware_job_governor_macros
// Assertion shorthands used by the governor's sequencer, mag_ctrl.
// ----------------------------------------------------------------------------
`ifndef MEMORY_AWARE_JOB_GOVERNOR_MACROS_SVH
`define MEMORY_AWARE_JOB_GOVERNOR_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define MAG_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("governor check failed");

// next-cycle implication, disabled while reset is asserted
`define MAG_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("governor check failed");

`endif

// ===== hdl/mag_pkg.sv =====
// ----------------------------------------------------------------------------
// mag_pkg
// Widths, register indexes, reset values and control types of the governor.
// ----------------------------------------------------------------------------
package mag_pkg;

	localparam int MEM_W     = 40;
	localparam int JOB_W     = 10;
	localparam int EXTRA_W   = 11;
	localparam int TIME_W    = 32;
	localparam int CFG_IDX_W = 3;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_MEM_PER_JOB  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MEM_CAP      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BASELINE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SAFE_LIMIT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LIMIT    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GROW_TIMEOUT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SAFE_TIMEOUT = 3'd6;

	// register reset values
	localparam logic [MEM_W-1:0]  MEM_PER_JOB_RST = 40'd1048576;
	localparam logic [JOB_W-1:0]  SAFE_LIMIT_RST  = 10'd1;
	localparam logic [JOB_W-1:0]  MAX_LIMIT_RST   = 10'd1;
	localparam logic [TIME_W-1:0] GROW_TO_RST     = 32'd2000;
	localparam logic [TIME_W-1:0] SAFE_TO_RST     = 32'd5000;

	// job count below which safe mode is entered, and the hard limit ceiling
	localparam logic [JOB_W-1:0] SAFE_ENTRY_JOBS = 10'd2;
	localparam logic [15:0]      MAX_JOBS        = 16'd1023;

	typedef logic [MEM_W-1:0] mem_t;
	typedef logic [JOB_W-1:0] job_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic start;
		logic eval;
		logic commit;
	} mag_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_busy;
		logic div_done;
	} mag_sts_t;

endpackage

// ===== hdl/mag_ifs.sv =====
// ----------------------------------------------------------------------------
// mag_ifs
// Request and response channels of the governor, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mag_req_if
	import mag_pkg::*;
();
	logic valid;
	logic ready;
	job_t running_jobs;
	mem_t used_memory;
	mem_t free_memory;
	mem_t available_memory;
	mem_t timestamp;

	modport source (output valid, running_jobs, used_memory, free_memory,
		available_memory, timestamp, input ready);
	modport sink (input valid, running_jobs, used_memory, free_memory,
		available_memory, timestamp, output ready);
endinterface

interface mag_rsp_if
	import mag_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic signed [EXTRA_W-1:0] extra_jobs;
	job_t                      job_limit_now;
	logic                      in_safe_mode;

	modport source (output valid, extra_jobs, job_limit_now, in_safe_mode,
		input ready);
	modport sink (input valid, extra_jobs, job_limit_now, in_safe_mode,
		output ready);
endinterface

// ===== hdl/mag_div.sv =====
// ----------------------------------------------------------------------------
// mag_div
// Restoring shift-subtract divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mag_div
	import mag_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  mem_t       dividend,
	input  mem_t       divisor,
	output logic       busy,
	output logic       done,
	output mem_t       quotient
);

	localparam int CNT_W = $clog2(MEM_W + 1);

	mem_t             rem_q;
	mem_t             quo_q;
	mem_t             dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [MEM_W:0]   trial;
	logic [MEM_W:0]   diff;
	logic             fits;

	// trial subtraction of the shifted partial remainder
	always_comb begin
		trial = {rem_q, quo_q[MEM_W-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = (trial >= {1'b0, dvs_q});
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(MEM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[MEM_W-1:0] : trial[MEM_W-1:0];
			quo_q <= {quo_q[MEM_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== hdl/mag_dp.sv =====
// ----------------------------------------------------------------------------
// mag_dp
// Governor datapath: registers, the two dividers, headroom count, the
// hysteresis update of the job limit and the result register.
// ----------------------------------------------------------------------------
module mag_dp
	import mag_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  mag_cmd_t                   cmd,
	output mag_sts_t                   sts,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  mem_t                       cfg_wdata,
	input  job_t                       running_jobs,
	input  mem_t                       used_memory,
	input  mem_t                       free_memory,
	input  mem_t                       available_memory,
	input  mem_t                       timestamp,
	output logic signed [EXTRA_W-1:0] extra_jobs,
	output job_t                       job_limit_now,
	output logic                       in_safe_mode
);

	// configuration registers
	mem_t              mpj_q;
	mem_t              cap_q;
	mem_t              base_q;
	job_t              safe_lim_q;
	job_t              max_lim_q;
	logic [TIME_W-1:0] grow_to_q;
	logic [TIME_W-1:0] safe_to_q;

	// governor state
	job_t              jl_q;
	logic              safe_q;
	mem_t              ws_q;

	// captured request and intermediate values
	job_t              run_q;
	mem_t              used_q;
	mem_t              free_q;
	mem_t              avail_q;
	mem_t              now_q;
	logic              full_q;
	logic              est_ok_q;
	mem_t              count_q;

	// result register
	logic [EXTRA_W-1:0] extra_q;
	job_t               jlo_q;
	logic               safeo_q;

	// divider hookup
	mem_t              room;
	mem_t              cap_left;
	mem_t              unit;
	mem_t              quo_est;
	mem_t              quo_cnt;
	logic              busy_est;
	logic              busy_cnt;
	logic              done_est;
	logic              done_cnt;

	// eval and commit
	mem_t              per_raw;
	mem_t              per_job;
	job_t              entry;
	logic              enter;
	job_t              jl1;
	logic              sf1;
	mem_t              ws1;
	mem_t              ws2;
	mem_t              elapsed;
	logic              cnt_lt2;
	logic              cnt_zero;
	logic              cnt_one;
	job_t              jl_n;
	logic              sf_n;
	mem_t              ws_n;
	logic              over;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mpj_q      <= MEM_PER_JOB_RST;
			cap_q      <= '0;
			base_q     <= '0;
			safe_lim_q <= SAFE_LIMIT_RST;
			max_lim_q  <= MAX_LIMIT_RST;
			grow_to_q  <= GROW_TO_RST;
			safe_to_q  <= SAFE_TO_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MEM_PER_JOB:  mpj_q      <= cfg_wdata;
				REG_MEM_CAP:      cap_q      <= cfg_wdata;
				REG_BASELINE:     base_q     <= cfg_wdata;
				REG_SAFE_LIMIT:   safe_lim_q <= cfg_wdata[JOB_W-1:0];
				REG_MAX_LIMIT:    max_lim_q  <= cfg_wdata[JOB_W-1:0];
				REG_GROW_TIMEOUT: grow_to_q  <= cfg_wdata[TIME_W-1:0];
				REG_SAFE_TIMEOUT: safe_to_q  <= cfg_wdata[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// headroom bounded by available memory, and the divisor
	always_comb begin
		cap_left = cap_q - used_q;
		room     = (avail_q < cap_left) ? avail_q : cap_left;
		unit     = (mpj_q == '0) ? mem_t'(1) : mpj_q;
	end

	// memory per job estimate: (used - baseline) / running
	mag_div u_div_est (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.start),
		.dividend (used_q - base_q),
		.divisor  ({{(MEM_W-JOB_W){1'b0}}, run_q}),
		.busy     (busy_est),
		.done     (done_est),
		.quotient (quo_est)
	);

	// candidate job count: room / per-job size
	mag_div u_div_cnt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.start),
		.dividend (room),
		.divisor  (unit),
		.busy     (busy_cnt),
		.done     (done_cnt),
		.quotient (quo_cnt)
	);

	assign sts.div_busy = busy_est | busy_cnt;
	assign sts.div_done = done_est & done_cnt;

	// request capture, early flags and candidate count
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			run_q   <= running_jobs;
			used_q  <= used_memory;
			free_q  <= free_memory;
			avail_q <= available_memory;
			now_q   <= timestamp;
		end
		if (cmd.start) begin
			full_q   <= ({1'b0, used_q} + {1'b0, mpj_q}) >= {1'b0, cap_q};
			est_ok_q <= (run_q != '0) && (used_q > base_q);
		end
		if (cmd.eval) begin
			count_q <= (full_q || (free_q <= per_job)) ? '0 : quo_cnt;
		end
	end

	// floor of the per-job estimate
	always_comb begin
		per_raw = est_ok_q ? quo_est : mpj_q;
		per_job = (per_raw < mpj_q) ? mpj_q : per_raw;
	end

	// safe-mode entry, hysteresis and clamp
	always_comb begin
		entry    = (safe_lim_q < SAFE_ENTRY_JOBS) ? safe_lim_q : SAFE_ENTRY_JOBS;
		enter    = (run_q < entry) && !safe_q;
		jl1      = enter ? safe_lim_q : jl_q;
		sf1      = enter | safe_q;
		ws1      = enter ? now_q : ws_q;
		cnt_zero = (count_q == '0);
		cnt_one  = (count_q == mem_t'(1));
		cnt_lt2  = cnt_zero | cnt_one;
		ws2      = cnt_lt2 ? now_q : ws1;
		elapsed  = now_q - ws2;
		jl_n     = jl1;
		sf_n     = sf1;
		ws_n     = ws2;
		priority if (sf1) begin
			if (elapsed > {{(MEM_W-TIME_W){1'b0}}, safe_to_q}) begin
				sf_n = 1'b0;
				ws_n = now_q;
			end
		end else if (cnt_zero && (run_q < jl1)) begin
			jl_n = run_q;
		end else if (cnt_one) begin
			sf_n = 1'b1;
		end else if (!cnt_zero
				&& (elapsed > {{(MEM_W-TIME_W){1'b0}}, grow_to_q})
				&& (jl1 < max_lim_q)
				&& ({{(16-JOB_W){1'b0}}, jl1} < MAX_JOBS)) begin
			jl_n = jl1 + job_t'(1);
			ws_n = now_q;
		end else begin
			// limit holds
			jl_n = jl1;
		end
		over = ({1'b0, count_q} + {{(MEM_W+1-JOB_W){1'b0}}, run_q})
			> {{(MEM_W+1-JOB_W){1'b0}}, jl_n};
	end

	// governor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jl_q   <= SAFE_LIMIT_RST;
			safe_q <= 1'b0;
			ws_q   <= '0;
		end else if (cmd.commit) begin
			jl_q   <= jl_n;
			safe_q <= sf_n;
			ws_q   <= ws_n;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			extra_q <= over ? ({1'b0, jl_n} - {1'b0, run_q}) : count_q[EXTRA_W-1:0];
			jlo_q   <= jl_n;
			safeo_q <= sf_n;
		end
	end

	assign extra_jobs    = signed'(extra_q);
	assign job_limit_now = jlo_q;
	assign in_safe_mode  = safeo_q;

endmodule

// ===== hdl/mag_ctrl.sv =====
// ----------------------------------------------------------------------------
// mag_ctrl
// Governor sequencer: request intake, divide, evaluate, commit into the
// result register.
// ----------------------------------------------------------------------------
`include "memory_aware_job_governor_macros.svh"

module mag_ctrl
	import mag_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output mag_cmd_t cmd,
	input  mag_sts_t sts
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_START  = 3'd1;
	localparam logic [2:0] ST_DIV    = 3'd2;
	localparam logic [2:0] ST_EVAL   = 3'd3;
	localparam logic [2:0] ST_COMMIT = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       rsp_valid_q;

	// next state and commands
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		req_ready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_START;
				end
			end
			ST_START: begin
				cmd.start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_done) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state register and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

	`MAG_ASSERT_NEXT(a_load_then_start, clk, arst_n, cmd.load, state_q == ST_START)
	`MAG_ASSERT_IMP(a_done_while_dividing, clk, arst_n, sts.div_done, state_q == ST_DIV)
	`MAG_ASSERT_IMP(a_commit_slot_free, clk, arst_n, cmd.commit, !rsp_valid_q || rsp_ready)
	`MAG_ASSERT_IMP(a_idle_dividers_quiet, clk, arst_n, state_q == ST_IDLE, !sts.div_busy)

endmodule

// ===== hdl/memory_aware_job_governor.sv =====
// ----------------------------------------------------------------------------
// memory_aware_job_governor
// Memory-aware job governor: per poll, how many more jobs may start.
// ----------------------------------------------------------------------------
// Each accepted request (running jobs, used/free/available memory, timestamp)
// yields one response: extra_jobs, the job limit after the poll and the safe
// mode flag. The sequencer starts two 40-step shift-subtract dividers (memory
// per job, and headroom over the per-job size) side by side, waits for their
// completion, evaluates the count and commits the limit update, the commit
// held while an unread response is not taken. One poll is in work at a time;
// a finished response waits in its output register while the next request is
// taken. The user must write configuration registers through the cfg_we /
// cfg_index / cfg_wdata port only while no poll is in work; the block does
// not enforce this. Indexes beyond the register list are ignored.
module memory_aware_job_governor
	import mag_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	mag_req_if.sink              req,
	mag_rsp_if.source            rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  mem_t                 cfg_wdata
);

	mag_cmd_t cmd;
	mag_sts_t sts;

	// sequencer
	mag_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// datapath
	mag_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.running_jobs     (req.running_jobs),
		.used_memory      (req.used_memory),
		.free_memory      (req.free_memory),
		.available_memory (req.available_memory),
		.timestamp        (req.timestamp),
		.extra_jobs       (rsp.extra_jobs),
		.job_limit_now    (rsp.job_limit_now),
		.in_safe_mode     (rsp.in_safe_mode)
	);

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the memory-aware job governor. A directed table of
// polls and register writes runs first, then randomized setting phases. Every
// response is compared field by field against its row's expected values or an
// in-bench model of the limit controller; requests are bursty, responses stall.
// ----------------------------------------------------------------------------
module tb_top;
	import mag_pkg::*;

	localparam int   CLK_HALF    = 4;
	localparam int   CYCLE_LIMIT = 2000000;
	localparam int   PHASES      = 8;
	localparam int   PHASE_POLLS = 104;
	localparam int   HOLD_AFTER  = 300;
	localparam int   HOLD_CYCLES = 300;
	localparam int   PRINT_CAP   = 100;
	localparam mem_t MEM_MAX     = '1;

	typedef struct {
		job_t running;
		mem_t used;
		mem_t free_mem;
		mem_t avail;
		mem_t stamp;
	} poll_t;

	typedef struct {
		logic signed [EXTRA_W-1:0] extra;
		job_t                      limit;
		logic                      safe;
	} verdict_t;

	typedef enum logic {ROW_CFG, ROW_POLL} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  index;
		mem_t                  value;
		poll_t                 poll;
		bit                    has_exp;
		verdict_t              exp;
	} row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	mem_t                 cfg_wdata;

	mag_req_if req_ch();
	mag_rsp_if rsp_ch();

	memory_aware_job_governor i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// governor registers as last written
	mem_t              gov_mem_per_job = MEM_PER_JOB_RST;
	mem_t              gov_cap         = '0;
	mem_t              gov_baseline    = '0;
	job_t              gov_safe_limit  = SAFE_LIMIT_RST;
	job_t              gov_max_limit   = MAX_LIMIT_RST;
	logic [TIME_W-1:0] gov_grow_to     = GROW_TO_RST;
	logic [TIME_W-1:0] gov_safe_to     = SAFE_TO_RST;

	// governor state
	job_t gov_limit  = SAFE_LIMIT_RST;
	logic gov_safe   = 1'b0;
	mem_t gov_window = '0;

	verdict_t    pending_verdicts[$];
	row_t        plan[$];
	mem_t        ts_now;
	int unsigned burst_left    = 0;
	int unsigned polls_taken   = 0;
	int unsigned verdicts_seen = 0;
	int unsigned mismatches    = 0;
	int unsigned cycles        = 0;

	// limit controller: safe-mode entry, headroom count, hysteresis, clamp
	function automatic verdict_t govern_poll(input poll_t p);
		logic [MEM_W:0]          per_job;
		logic [MEM_W:0]          load;
		logic [MEM_W:0]          room;
		logic [MEM_W:0]          count;
		mem_t                    divisor;
		job_t                    entry_jobs;
		logic signed [EXTRA_W:0] margin;
		verdict_t                v;

		entry_jobs = (gov_safe_limit < SAFE_ENTRY_JOBS) ? gov_safe_limit : SAFE_ENTRY_JOBS;
		if (p.running < entry_jobs && !gov_safe) begin
			gov_limit  = gov_safe_limit;
			gov_safe   = 1'b1;
			gov_window = p.stamp;
		end

		// per-job memory estimate, floored at the configured size
		per_job = {1'b0, gov_mem_per_job};
		if (p.running != '0 && p.used > gov_baseline)
			per_job = {1'b0, p.used - gov_baseline}
				/ {{(MEM_W+1-JOB_W){1'b0}}, p.running};
		if (per_job < {1'b0, gov_mem_per_job})
			per_job = {1'b0, gov_mem_per_job};

		// how many more jobs fit below the cap
		load = {1'b0, p.used} + {1'b0, gov_mem_per_job};
		if (load >= {1'b0, gov_cap} || {1'b0, p.free_mem} <= per_job) begin
			count = '0;
		end else begin
			room = {1'b0, gov_cap - p.used};
			if ({1'b0, p.avail} < room)
				room = {1'b0, p.avail};
			divisor = (gov_mem_per_job != '0) ? gov_mem_per_job : mem_t'(1);
			count = room / {1'b0, divisor};
		end

		// hysteresis
		if (count < 2)
			gov_window = p.stamp;
		if (gov_safe) begin
			if (mem_t'(p.stamp - gov_window) > gov_safe_to) begin
				gov_safe   = 1'b0;
				gov_window = p.stamp;
			end
		end else if (count == 0 && p.running < gov_limit) begin
			gov_limit = p.running;
		end else if (count == 1) begin
			gov_safe = 1'b1;
		end else if (count > 0 && mem_t'(p.stamp - gov_window) > gov_grow_to &&
				gov_limit < gov_max_limit && gov_limit < MAX_JOBS) begin
			gov_limit  = gov_limit + job_t'(1);
			gov_window = p.stamp;
		end

		// clamp to the limit
		if (count + p.running > gov_limit) begin
			margin  = $signed({2'b00, gov_limit}) - $signed({2'b00, p.running});
			v.extra = margin[EXTRA_W-1:0];
		end else begin
			v.extra = count[EXTRA_W-1:0];
		end
		v.limit = gov_limit;
		v.safe  = gov_safe;
		return v;
	endfunction

	function automatic mem_t rand_upto(input logic [63:0] hi);
		logic [63:0] r;
		r = {$urandom, $urandom};
		if (hi >= 64'(MEM_MAX))
			return r[MEM_W-1:0];
		return mem_t'(r % (hi + 64'd1));
	endfunction

	// zero, the top value or anything in between
	function automatic mem_t pick_edge(input mem_t top);
		case ($urandom_range(0, 2))
			0: return '0;
			1: return top;
			default: return rand_upto(64'(top));
		endcase
	endfunction

	// mostly plausible readings around the current settings, some noise
	function automatic poll_t make_poll();
		poll_t       p;
		logic [63:0] top;
		logic [63:0] used_w;

		if ($urandom_range(0, 9) == 0) begin
			p.running = job_t'($urandom);
			p.used     = rand_upto(64'(MEM_MAX));
			p.free_mem = rand_upto(64'(MEM_MAX));
			p.avail    = rand_upto(64'(MEM_MAX));
			if ($urandom_range(0, 1) == 0)
				ts_now = rand_upto(64'(MEM_MAX));
			else
				ts_now = ts_now + mem_t'($urandom_range(0, 200));
		end else begin
			if ($urandom_range(0, 3) == 0)
				p.running = job_t'($urandom_range(0, 2));
			else if ($urandom_range(0, 7) == 0)
				p.running = job_t'($urandom);
			else
				p.running = job_t'($urandom_range(0, gov_max_limit + 4));
			top = (gov_cap > gov_baseline) ? 64'(gov_cap - gov_baseline) : 64'd0;
			used_w = 64'(gov_baseline) + 64'(rand_upto(top + 64'(gov_mem_per_job)));
			p.used = (used_w > 64'(MEM_MAX)) ? MEM_MAX : used_w[MEM_W-1:0];
			if ($urandom_range(0, 5) == 0)
				p.free_mem = rand_upto(64'(gov_mem_per_job) * 2);
			else
				p.free_mem = rand_upto(64'(gov_cap) + 64'(gov_mem_per_job));
			top = (gov_cap > p.used) ? 64'(gov_cap - p.used) : 64'd0;
			if ($urandom_range(0, 3) == 0)
				p.avail = rand_upto(64'(MEM_MAX));
			else
				p.avail = rand_upto(top + 64'(gov_mem_per_job) * 2);
			if ($urandom_range(0, 19) == 0)
				ts_now = ts_now + rand_upto(64'(MEM_MAX));
			else
				ts_now = ts_now + mem_t'($urandom_range(0, 200));
		end
		p.stamp = ts_now;
		return p;
	endfunction

	function automatic void row_cfg(input logic [CFG_IDX_W-1:0] index, input mem_t value);
		row_t r;
		r.kind    = ROW_CFG;
		r.index   = index;
		r.value   = value;
		r.has_exp = 1'b0;
		plan.push_back(r);
	endfunction

	function automatic void row_poll(input job_t running, input mem_t used,
			input mem_t free_mem, input mem_t avail, input mem_t stamp,
			input bit typed = 1'b0, input int extra = 0, input int limit = 0,
			input bit safe = 1'b0);
		row_t r;
		r.kind          = ROW_POLL;
		r.index         = '0;
		r.value         = '0;
		r.poll.running  = running;
		r.poll.used     = used;
		r.poll.free_mem = free_mem;
		r.poll.avail    = avail;
		r.poll.stamp    = stamp;
		r.has_exp       = typed;
		r.exp.extra     = extra[EXTRA_W-1:0];
		r.exp.limit     = job_t'(limit);
		r.exp.safe      = safe;
		plan.push_back(r);
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (mismatches < PRINT_CAP)
			$display("%0t: response %0d %s: got %0d, expected %0d",
				$time, verdicts_seen, what, got, want);
		mismatches++;
	endtask

	// register write, leaves the write enable high for a following write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input mem_t value);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= value;
		@(posedge clk);
		case (index)
			REG_MEM_PER_JOB:  gov_mem_per_job = value;
			REG_MEM_CAP:      gov_cap         = value;
			REG_BASELINE:     gov_baseline    = value;
			REG_SAFE_LIMIT:   gov_safe_limit  = value[JOB_W-1:0];
			REG_MAX_LIMIT:    gov_max_limit   = value[JOB_W-1:0];
			REG_GROW_TIMEOUT: gov_grow_to     = value[TIME_W-1:0];
			REG_SAFE_TIMEOUT: gov_safe_to     = value[TIME_W-1:0];
			default: ;
		endcase
	endtask

	// offer one request in bursts with random gaps, predict on acceptance
	task automatic issue_poll(input poll_t p, input bit typed, input verdict_t typed_v);
		int unsigned gap;
		verdict_t    predicted;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			case ($urandom_range(0, 3))
				0: gap = 0;
				1: gap = $urandom_range(1, 60);
				default: gap = $urandom_range(1, 6);
			endcase
			if (gap != 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_ch.valid            <= 1'b1;
		req_ch.running_jobs     <= p.running;
		req_ch.used_memory      <= p.used;
		req_ch.free_memory      <= p.free_mem;
		req_ch.available_memory <= p.avail;
		req_ch.timestamp        <= p.stamp;
		do @(posedge clk); while (!req_ch.ready);
		polls_taken++;
		predicted = govern_poll(p);
		pending_verdicts.push_back(typed ? typed_v : predicted);
	endtask

	// stop offering and let every pending response come back
	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("memory_aware_job_governor verification failed");
			$finish;
		end
	end

	// response check against the oldest prediction
	always @(posedge clk) begin : check_rsp
		verdict_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_verdicts.size() == 0) begin
				report_mismatch("unexpected, extra_jobs", rsp_ch.extra_jobs, 0);
			end else begin
				want = pending_verdicts.pop_front();
				if (rsp_ch.extra_jobs !== want.extra)
					report_mismatch("extra_jobs", rsp_ch.extra_jobs, want.extra);
				if (rsp_ch.job_limit_now !== want.limit)
					report_mismatch("job_limit_now", rsp_ch.job_limit_now, want.limit);
				if (rsp_ch.in_safe_mode !== want.safe)
					report_mismatch("in_safe_mode", rsp_ch.in_safe_mode, want.safe);
			end
			verdicts_seen++;
		end
	end

	// response side stalls, plus one long hold-off to back up the request side
	initial begin : rsp_pacing
		int unsigned span;
		int unsigned mode;
		int unsigned k;
		int unsigned h;
		logic [15:0] pattern;
		bit          held;
		held = 1'b0;
		rsp_ch.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			span    = $urandom_range(20, 200);
			mode    = $urandom_range(0, 3);
			pattern = 16'($urandom);
			for (k = 0; k < span; k++) begin
				if (!held && polls_taken >= HOLD_AFTER) begin
					rsp_ch.ready <= 1'b0;
					for (h = 0; h < HOLD_CYCLES; h++)
						@(posedge clk);
					held = 1'b1;
				end
				case (mode)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= pattern[k % 16];
					2: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
					default: rsp_ch.ready <= 1'($urandom_range(0, 1));
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin : stimulus
		verdict_t          no_verdict;
		mem_t              new_mpj;
		mem_t              new_cap;
		mem_t              new_base;
		job_t              new_safe;
		job_t              new_max;
		logic [TIME_W-1:0] new_grow;
		logic [TIME_W-1:0] new_sto;
		int                phase;

		no_verdict = '{extra: '0, limit: '0, safe: 1'b0};
		ts_now     = '0;

		arst_n                  <= 1'b0;
		cfg_we                  <= 1'b0;
		cfg_index               <= '0;
		cfg_wdata               <= '0;
		req_ch.valid            <= 1'b0;
		req_ch.running_jobs     <= '0;
		req_ch.used_memory      <= '0;
		req_ch.free_memory      <= '0;
		req_ch.available_memory <= '0;
		req_ch.timestamp        <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// settings after reset: no cap, so every poll sees no headroom
		row_poll(0, 0, 0, 0, 0, 1'b1, 0, 1, 1'b1);
		row_poll(5, MEM_MAX, MEM_MAX, MEM_MAX, 40'd6000, 1'b1, -4, 1, 1'b1);
		row_poll(1023, MEM_MAX, MEM_MAX, MEM_MAX, MEM_MAX, 1'b1, -1022, 1, 1'b1);
		// leave safe mode across the timestamp wrap, then grow to max_job_limit
		row_cfg(REG_MEM_PER_JOB, 40'd1000);
		row_cfg(REG_MEM_CAP, 40'd100000);
		row_cfg(REG_BASELINE, 40'd0);
		row_cfg(REG_SAFE_LIMIT, 40'd4);
		row_cfg(REG_MAX_LIMIT, 40'd6);
		row_cfg(REG_GROW_TIMEOUT, 40'd10);
		row_cfg(REG_SAFE_TIMEOUT, 40'd20);
		row_poll(3, 40'd10000, 40'd50000, 40'd90000, 40'd100);
		row_poll(3, 40'd10000, 40'd50000, 40'd90000, 40'd200);
		row_poll(3, 40'd10000, 40'd50000, 40'd90000, 40'd250);
		row_poll(3, 40'd10000, 40'd50000, 40'd90000, 40'd300);
		row_poll(3, 40'd10000, 40'd50000, 40'd90000, 40'd350);
		row_poll(3, 40'd10000, 40'd50000, 40'd90000, 40'd400);
		row_poll(3, 40'd10000, 40'd50000, 40'd90000, 40'd450);
		// room for one job only re-arms safe mode, headroom releases it
		row_poll(3, 40'd98500, 40'd50000, MEM_MAX, 40'd460);
		row_poll(3, 40'd10000, 40'd50000, 40'd90000, 40'd1000);
		// at the cap the limit drops, then free memory below the estimate
		row_poll(2, 40'd100000, 40'd50000, 40'd90000, 40'd1010);
		row_poll(3, 40'd10000, 40'd3000, 40'd90000, 40'd1020);
		// new safe limit only applies at the next safe-mode entry
		row_cfg(REG_SAFE_LIMIT, 40'd1023);
		row_poll(4, 40'd10000, 40'd50000, 40'd90000, 40'd1030);
		row_poll(1, 40'd5000, 40'd50000, 40'd90000, 40'd1040);
		// zero per-job size divides by one, limit stuck at the ceiling
		row_cfg(REG_MEM_PER_JOB, 40'd0);
		row_cfg(REG_MEM_CAP, MEM_MAX);
		row_cfg(REG_BASELINE, MEM_MAX);
		row_cfg(REG_MAX_LIMIT, 40'd1023);
		row_cfg(REG_GROW_TIMEOUT, 40'd0);
		row_cfg(REG_SAFE_TIMEOUT, 40'd0);
		row_poll(1023, 40'd0, MEM_MAX, MEM_MAX, 40'd1041);
		row_poll(1000, 40'd0, MEM_MAX, MEM_MAX, 40'd1050);
		row_poll(500, 40'd12345, 40'd1, 40'd0, 40'd1060);
		// widest per-job size, longest timeouts, smallest limits
		row_cfg(REG_MEM_PER_JOB, MEM_MAX);
		row_cfg(REG_BASELINE, 40'd0);
		row_cfg(REG_SAFE_LIMIT, 40'd1);
		row_cfg(REG_MAX_LIMIT, 40'd1);
		row_cfg(REG_GROW_TIMEOUT, 40'hFFFF_FFFF);
		row_cfg(REG_SAFE_TIMEOUT, 40'hFFFF_FFFF);
		row_poll(1, MEM_MAX, MEM_MAX, MEM_MAX, 40'd0);
		row_poll(0, 40'd0, MEM_MAX, MEM_MAX, MEM_MAX);

		foreach (plan[n]) begin
			if (plan[n].kind == ROW_CFG) begin
				if (n == 0 || plan[n-1].kind != ROW_CFG)
					wait_idle();
				write_reg(plan[n].index, plan[n].value);
			end else begin
				cfg_we <= 1'b0;
				issue_poll(plan[n].poll, plan[n].has_exp, plan[n].exp);
			end
		end

		// random phases, each with fresh settings
		for (phase = 0; phase < PHASES; phase++) begin
			wait_idle();
			if ($urandom_range(0, 4) == 0) begin
				new_mpj  = pick_edge(MEM_MAX);
				new_cap  = pick_edge(MEM_MAX);
				new_base = pick_edge(MEM_MAX);
				new_safe = job_t'(pick_edge(40'd1023));
				new_max  = job_t'(pick_edge(40'd1023));
				new_grow = TIME_W'(pick_edge(40'hFFFF_FFFF));
				new_sto  = TIME_W'(pick_edge(40'hFFFF_FFFF));
			end else begin
				new_mpj  = mem_t'($urandom_range(1, 65536));
				new_base = mem_t'($urandom_range(0, 1 << 20));
				new_cap  = new_base + new_mpj * $urandom_range(0, 64) + $urandom_range(0, 1000);
				if ($urandom_range(0, 7) == 0)
					new_safe = job_t'($urandom);
				else
					new_safe = job_t'($urandom_range(1, 6));
				new_max  = job_t'($urandom_range(1, 48));
				new_grow = $urandom_range(0, 300);
				new_sto  = $urandom_range(0, 600);
			end
			write_reg(REG_MEM_PER_JOB, new_mpj);
			write_reg(REG_MEM_CAP, new_cap);
			write_reg(REG_BASELINE, new_base);
			write_reg(REG_SAFE_LIMIT, mem_t'(new_safe));
			write_reg(REG_MAX_LIMIT, mem_t'(new_max));
			write_reg(REG_GROW_TIMEOUT, mem_t'(new_grow));
			write_reg(REG_SAFE_TIMEOUT, mem_t'(new_sto));
			cfg_we <= 1'b0;
			// start some phases just short of the timestamp wrap
			if ($urandom_range(0, 1) == 0)
				ts_now = MEM_MAX - mem_t'($urandom_range(0, 5000));
			else
				ts_now = rand_upto(64'(MEM_MAX));
			repeat (PHASE_POLLS)
				issue_poll(make_poll(), 1'b0, no_verdict);
		end

		wait_idle();
		repeat (60) @(posedge clk);
		if (mismatches == 0)
			$display("memory_aware_job_governor verification clean");
		else
			$display("memory_aware_job_governor verification failed");
		$finish;
	end

endmodule
